// File: rtl/xyz_zoom_clip_wrap_fold_assert.svh
// Assertion macros used by the queue RTL file of the zoom, clip, wrap and fold block.
`ifndef XYZ_ZOOM_CLIP_WRAP_FOLD_ASSERT_SVH
`define XYZ_ZOOM_CLIP_WRAP_FOLD_ASSERT_SVH

// Same-cycle implication, checked on clock and disabled during reset.
`define ZCWF_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on clock and disabled during reset.
`define ZCWF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/zcwf_pkg.sv
// Package with the shared types and constants of the zoom, clip, wrap and fold block.
package zcwf_pkg;

   localparam int SAMPLE_BITS_DEFAULT = 24;
   localparam int FRAC_BITS_DEFAULT   = 16;
   localparam int QUEUE_DEPTH         = 2;
   localparam int CSR_INDEX_BITS      = 2;
   localparam int CSR_DATA_BITS       = 1;
   localparam int LANES               = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_WRAP   = 2'd0,
      CSR_MIRROR = 2'd1,
      CSR_BYPASS = 2'd2
   } zcwf_csr_type;

   typedef struct packed {
      logic bypass;
      logic mirror;
      logic wrap;
   } zcwf_mode_type;

endpackage

// File: rtl/zcwf_if.sv
// Channel interfaces for the sample beats and the result beats.
interface zcwf_req_if #(
   parameter int SAMPLE_BITS = zcwf_pkg::SAMPLE_BITS_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] x_sample;
   logic signed [SAMPLE_BITS-1:0] y_sample;
   logic signed [SAMPLE_BITS-1:0] z_sample;
   logic signed [SAMPLE_BITS-1:0] max_level;
   logic signed [SAMPLE_BITS-1:0] zoom_level;

   modport source (output valid, x_sample, y_sample, z_sample, max_level, zoom_level,
                   input ready);
   modport sink (input valid, x_sample, y_sample, z_sample, max_level, zoom_level,
                 output ready);
endinterface

interface zcwf_rsp_if #(
   parameter int SAMPLE_BITS = zcwf_pkg::SAMPLE_BITS_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] x_result;
   logic signed [SAMPLE_BITS-1:0] y_result;
   logic signed [SAMPLE_BITS-1:0] z_result;

   modport source (output valid, x_result, y_result, z_result, input ready);
   modport sink (input valid, x_result, y_result, z_result, output ready);
endinterface

// File: rtl/xyz_zoom_clip_wrap_fold.sv
// Top level of the three-axis zoom window with clip, wrap or fold and gain.
// Throughput: one beat per cycle while the result channel is ready. Path: front stage, queue,
// remainder divider, confine, product, gain divider, result. Dividers are bit-per-stage.
// Reset is synchronous and active high; it clears the mode registers, the queue and all
// valid flags, and the block accepts beats in the first cycle after reset.
module xyz_zoom_clip_wrap_fold
   import zcwf_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
   parameter int FRAC_BITS   = FRAC_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   zcwf_req_if.sink                  req_chan,
   zcwf_rsp_if.source                rsp_chan,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);
   localparam int ITEM_BITS = 5 * SAMPLE_BITS - 2 + $bits(zcwf_mode_type);

   // Mode registers. The front stage copies them into every beat it takes, so a
   // beat keeps the modes it was accepted under all the way down the pipeline.
   zcwf_mode_type        mode_ff, mode_in;

   logic                 push, pop, full, empty;
   logic [ITEM_BITS-1:0] push_data, pop_data;

   always_comb begin
      mode_in = mode_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_WRAP:   mode_in.wrap   = csr_wdata[0];
            CSR_MIRROR: mode_in.mirror = csr_wdata[0];
            CSR_BYPASS: mode_in.bypass = csr_wdata[0];
            default:    mode_in = mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= '0;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // The front stage clamps level and zoom; the queue lets it keep taking beats
   // while the back pipeline is held by the result channel, until the queue fills.
   zcwf_front #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .FRAC_BITS  (FRAC_BITS),
      .ITEM_BITS  (ITEM_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .mode     (mode_ff),
      .full     (full),
      .push     (push),
      .push_data(push_data)
   );

   zcwf_queue #(
      .WIDTH(ITEM_BITS),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .pop      (pop),
      .pop_data (pop_data),
      .full     (full),
      .empty    (empty)
   );

   // The back pipeline moves as a whole whenever its result register is free or
   // being drained.
   zcwf_back #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .ITEM_BITS  (ITEM_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .empty    (empty),
      .pop_data (pop_data),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// File: rtl/zcwf_queue.sv
// Short register queue between the front stage and the back pipeline.
`include "xyz_zoom_clip_wrap_fold_assert.svh"

module zcwf_queue
   import zcwf_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `ZCWF_ASSERT_IMPLY(a_no_overflow, push, !full, "push into a full queue")
   `ZCWF_ASSERT_IMPLY(a_no_underflow, pop, !empty, "pop from an empty queue")
   `ZCWF_ASSERT_NEXT(a_count_rise, push && !pop, count_ff == CNT_W'($past(count_ff) + 1'b1), "queue count did not rise on push")

endmodule

// File: rtl/zcwf_front.sv
// Front stage: takes sample beats, clamps level and zoom, snapshots the mode bits.
module zcwf_front
   import zcwf_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
   parameter int FRAC_BITS   = FRAC_BITS_DEFAULT,
   parameter int ITEM_BITS   = 5 * SAMPLE_BITS - 2 + $bits(zcwf_mode_type)
) (
   input  logic                 clock,
   input  logic                 reset,
   zcwf_req_if.sink             req_chan,
   input  zcwf_mode_type        mode,
   input  logic                 full,
   output logic                 push,
   output logic [ITEM_BITS-1:0] push_data
);
   localparam int SB            = SAMPLE_BITS;
   localparam int LevelFloorInt = ((1 << FRAC_BITS) + 500) / 1000;
   localparam logic signed [SB-1:0] LevelFloor = SB'(LevelFloorInt);

   logic                 valid_ff, valid_in;
   logic [ITEM_BITS-1:0] item_ff, item_in;
   logic signed [SB-1:0] level_c, zoom_c, zoom_f;
   logic                 take;

   // No beat is taken while reset is held, since it would be dropped.
   assign req_chan.ready = !reset && !(valid_ff && full);
   assign take           = req_chan.valid && req_chan.ready;
   assign push           = valid_ff && !full;
   assign push_data      = item_ff;

   always_comb begin
      level_c = (req_chan.max_level < LevelFloor) ? LevelFloor : req_chan.max_level;
      zoom_f  = (req_chan.zoom_level < LevelFloor) ? LevelFloor : req_chan.zoom_level;
      zoom_c  = (zoom_f > level_c) ? level_c : zoom_f;
      // Layout: mode, zoom, level, z, y, x from the top down.
      item_in = {mode, zoom_c[SB-2:0], level_c[SB-2:0],
                 req_chan.z_sample, req_chan.y_sample, req_chan.x_sample};
      valid_in = req_chan.ready ? req_chan.valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

endmodule

// File: rtl/zcwf_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, shared divisor over lanes.
module zcwf_div_pipe
   import zcwf_pkg::*;
#(
   parameter int NW = 24,
   parameter int DW = 24,
   parameter int QW = 24,
   parameter int TW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          in_valid,
   input  logic [NW-1:0] dividend [LANES],
   input  logic [DW-1:0] divisor,
   input  logic [TW-1:0] tag_in,
   output logic          out_valid,
   output logic [QW-1:0] quotient [LANES],
   output logic [DW-1:0] remainder [LANES],
   output logic [TW-1:0] tag_out
);
   logic          valid_ff [QW];
   logic [DW-1:0] div_ff   [QW];
   logic [TW-1:0] tag_ff   [QW];
   logic [DW-1:0] rem_ff   [QW][LANES];
   logic [QW-1:0] low_ff   [QW][LANES];
   logic [QW-1:0] quo_ff   [QW][LANES];
   logic [DW-1:0] rem_in   [QW][LANES];
   logic [QW-1:0] low_in   [QW][LANES];
   logic [QW-1:0] quo_in   [QW][LANES];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic          src_valid;
      logic [DW-1:0] src_div;
      logic [TW-1:0] src_tag;
      logic [DW-1:0] src_rem [LANES];
      logic [QW-1:0] src_low [LANES];
      logic [QW-1:0] src_quo [LANES];

      if (k == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_div   = divisor;
         assign src_tag   = tag_in;
         for (genvar l = 0; l < LANES; l++) begin : g_lane
            // The bits above the quotient width are known to stay below the divisor.
            if (NW > QW) begin : g_head
               assign src_rem[l] = DW'(dividend[l][NW-1:QW]);
            end else begin : g_nohead
               assign src_rem[l] = '0;
            end
            assign src_low[l] = dividend[l][QW-1:0];
            assign src_quo[l] = '0;
         end
      end else begin : g_next
         assign src_valid = valid_ff[k-1];
         assign src_div   = div_ff[k-1];
         assign src_tag   = tag_ff[k-1];
         for (genvar l = 0; l < LANES; l++) begin : g_lane
            assign src_rem[l] = rem_ff[k-1][l];
            assign src_low[l] = low_ff[k-1][l];
            assign src_quo[l] = quo_ff[k-1][l];
         end
      end

      for (genvar l = 0; l < LANES; l++) begin : g_step
         always_comb begin
            logic [DW:0] trial;
            logic        qbit;
            trial = {src_rem[l], src_low[l][QW-1]};
            qbit  = (trial >= {1'b0, src_div});
            rem_in[k][l] = qbit ? DW'(trial - {1'b0, src_div}) : trial[DW-1:0];
            low_in[k][l] = src_low[l] << 1;
            quo_in[k][l] = {src_quo[l][QW-2:0], qbit};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            div_ff[k] <= src_div;
            tag_ff[k] <= src_tag;
            for (int l = 0; l < LANES; l++) begin
               rem_ff[k][l] <= rem_in[k][l];
               low_ff[k][l] <= low_in[k][l];
               quo_ff[k][l] <= quo_in[k][l];
            end
         end
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign tag_out   = tag_ff[QW-1];
   for (genvar l = 0; l < LANES; l++) begin : g_out
      assign quotient[l]  = quo_ff[QW-1][l];
      assign remainder[l] = rem_ff[QW-1][l];
   end

endmodule

// File: rtl/zcwf_back.sv
// Back pipeline: clip, wrap or fold, gain level/zoom, round and saturate, or bypass.
module zcwf_back
   import zcwf_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
   parameter int ITEM_BITS   = 5 * SAMPLE_BITS - 2 + $bits(zcwf_mode_type)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 empty,
   input  logic [ITEM_BITS-1:0] pop_data,
   output logic                 pop,
   zcwf_rsp_if.source           rsp_chan
);
   localparam int SB     = SAMPLE_BITS;
   localparam int MW     = $bits(zcwf_mode_type);
   localparam int PW     = 2 * SB - 2;
   localparam int TAG2_W = 4 * SB + 3;

   logic advance;

   // Stage 0: operands of the remainder divider.
   logic signed [SB-1:0] s0_v [LANES];
   logic [SB-2:0]        s0_zoom;
   zcwf_mode_type        s0_mode;
   logic [SB-1:0]        d1_dividend [LANES];
   logic [SB:0]          d1_divisor;

   // Remainder divider outputs.
   logic                 d1_valid;
   logic [SB:0]          d1_rem [LANES];
   logic [ITEM_BITS-1:0] d1_item;
   logic signed [SB-1:0] d1_v [LANES];
   logic [SB-2:0]        d1_zoom;
   zcwf_mode_type        d1_mode;

   // Confined value stage.
   logic                 c_valid_ff;
   logic [ITEM_BITS-1:0] c_item_ff;
   logic signed [SB-1:0] conf_ff [LANES];
   logic signed [SB-1:0] conf_in [LANES];
   logic [SB-2:0]        c_level;

   // Product stage.
   logic                 m_valid_ff;
   logic [ITEM_BITS-1:0] m_item_ff;
   logic [PW-1:0]        prod_ff [LANES];
   logic [PW-1:0]        prod_in [LANES];
   logic [LANES-1:0]     neg_ff, neg_in;
   zcwf_mode_type        m_mode;
   logic [TAG2_W-1:0]    d2_tag_in;

   // Quotient divider outputs.
   logic                 d2_valid;
   logic [SB-2:0]        d2_quo [LANES];
   logic [SB-2:0]        d2_rem [LANES];
   logic [TAG2_W-1:0]    d2_tag;
   logic [SB-2:0]        o_zoom;
   logic [LANES-1:0]     o_neg;
   logic                 o_bypass;
   logic signed [SB-1:0] o_samp [LANES];

   // Result register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [SB-1:0] res_ff [LANES];
   logic signed [SB-1:0] res_in [LANES];

   assign advance = !rsp_valid_ff || rsp_chan.ready;
   assign pop     = advance && !empty;

   assign s0_zoom = pop_data[5*SB-3:4*SB-1];
   assign s0_mode = zcwf_mode_type'(pop_data[ITEM_BITS-1:ITEM_BITS-MW]);
   assign d1_zoom = d1_item[5*SB-3:4*SB-1];
   assign d1_mode = zcwf_mode_type'(d1_item[ITEM_BITS-1:ITEM_BITS-MW]);
   assign c_level = c_item_ff[4*SB-2:3*SB];
   assign m_mode  = zcwf_mode_type'(m_item_ff[ITEM_BITS-1:ITEM_BITS-MW]);

   // Wrap divides by zoom; a lone fold divides by the fold period of four zooms.
   assign d1_divisor = s0_mode.wrap ? (SB+1)'(s0_zoom) : {s0_zoom, 2'b00};

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      assign s0_v[l] = $signed(pop_data[l*SB +: SB]);
      assign d1_v[l] = $signed(d1_item[l*SB +: SB]);

      always_comb begin
         logic signed [SB:0] v_ext, u_ext, v_abs, u_abs;
         v_ext = {s0_v[l][SB-1], s0_v[l]};
         u_ext = v_ext + $signed({2'b00, s0_zoom});
         v_abs = (v_ext < 0) ? -v_ext : v_ext;
         u_abs = (u_ext < 0) ? -u_ext : u_ext;
         d1_dividend[l] = (s0_mode.wrap || !s0_mode.mirror) ? v_abs[SB-1:0] : u_abs[SB-1:0];
      end

      // The value is confined to [-zoom, zoom]; a value on a bound is kept in every mode.
      always_comb begin
         logic signed [SB+1:0] v, z, r, p, rr, res;
         logic                 outside;
         v       = {{2{d1_v[l][SB-1]}}, d1_v[l]};
         z       = $signed({3'b000, d1_zoom});
         r       = $signed({1'b0, d1_rem[l]});
         p       = z <<< 2;
         rr      = r;
         outside = (v > z) || (v < -z);
         if (!outside) begin
            res = v;
         end else if (!d1_mode.wrap && !d1_mode.mirror) begin
            res = (v > z) ? z : -z;
         end else if (d1_mode.wrap) begin
            res = (v < 0) ? -r : r;
         end else begin
            // Floored remainder of v + zoom, then a triangle fold.
            if (((v + z) < 0) && (r != 0)) begin
               rr = p - r;
            end
            res = (rr <= (z <<< 1)) ? rr - z : (z <<< 1) + z - rr;
         end
         conf_in[l] = $signed(res[SB-1:0]);
      end

      always_comb begin
         logic [SB-1:0] mag;
         mag        = (conf_ff[l] < 0) ? -conf_ff[l] : conf_ff[l];
         prod_in[l] = PW'(mag[SB-2:0]) * PW'(c_level);
         neg_in[l]  = (conf_ff[l] < 0);
      end

      assign o_samp[l] = $signed(d2_tag[l*SB +: SB]);

      // Round half away from zero on the magnitude, then saturate.
      always_comb begin
         logic          rup;
         logic [SB-1:0] qr;
         rup = (d2_rem[l] >= (o_zoom - d2_rem[l]));
         qr  = {1'b0, d2_quo[l]} + SB'(rup);
         if (o_bypass) begin
            res_in[l] = o_samp[l];
         end else if (o_neg[l]) begin
            res_in[l] = -$signed(qr);
         end else if (qr[SB-1]) begin
            res_in[l] = $signed({1'b0, {(SB-1){1'b1}}});
         end else begin
            res_in[l] = $signed(qr);
         end
      end
   end

   zcwf_div_pipe #(
      .NW(SB),
      .DW(SB + 1),
      .QW(SB),
      .TW(ITEM_BITS)
   ) u_rem_div (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (pop),
      .dividend (d1_dividend),
      .divisor  (d1_divisor),
      .tag_in   (pop_data),
      .out_valid(d1_valid),
      .quotient (),
      .remainder(d1_rem),
      .tag_out  (d1_item)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         m_valid_ff <= 1'b0;
      end else if (advance) begin
         c_valid_ff <= d1_valid;
         m_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c_item_ff <= d1_item;
         m_item_ff <= c_item_ff;
         neg_ff    <= neg_in;
         for (int l = 0; l < LANES; l++) begin
            conf_ff[l] <= conf_in[l];
            prod_ff[l] <= prod_in[l];
         end
      end
   end

   assign d2_tag_in = {m_item_ff[5*SB-3:4*SB-1], neg_ff, m_mode.bypass, m_item_ff[3*SB-1:0]};

   zcwf_div_pipe #(
      .NW(PW),
      .DW(SB - 1),
      .QW(SB - 1),
      .TW(TAG2_W)
   ) u_gain_div (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (m_valid_ff),
      .dividend (prod_ff),
      .divisor  (m_item_ff[5*SB-3:4*SB-1]),
      .tag_in   (d2_tag_in),
      .out_valid(d2_valid),
      .quotient (d2_quo),
      .remainder(d2_rem),
      .tag_out  (d2_tag)
   );

   assign o_zoom   = d2_tag[TAG2_W-1:3*SB+4];
   assign o_neg    = d2_tag[3*SB+3:3*SB+1];
   assign o_bypass = d2_tag[3*SB];

   assign rsp_valid_in = advance ? d2_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int l = 0; l < LANES; l++) begin
            res_ff[l] <= res_in[l];
         end
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.x_result = res_ff[0];
   assign rsp_chan.y_result = res_ff[1];
   assign rsp_chan.z_result = res_ff[2];

endmodule
